[rtl/core/parameter_glide_smoother_top_defines.svh]
// Assertion macros for the parameter glide smoother checker.
// Included by the checker file; no other dependencies.
`ifndef PARAMETER_GLIDE_SMOOTHER_TOP_DEFINES_SVH
`define PARAMETER_GLIDE_SMOOTHER_TOP_DEFINES_SVH
`define PGS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define PGS_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

[rtl/core/pgs_pkg.sv]
// Package for the parameter glide smoother: codes, widths and reset values.
// No dependencies.
`default_nettype none
package pgs_pkg;
    localparam int MAX_TRANSITION  = 16384;
    localparam int INNER_FRAC_BITS = 56;
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_GLIDE = 2'd1;
    localparam logic [1:0] KIND_SET   = 2'd2;
    localparam logic [1:0] KIND_PULSE = 2'd3;
    localparam logic [1:0] MODE_LINEAR = 2'd0;
    localparam logic [1:0] MODE_ADAPT  = 2'd1;
    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_TRANS  = 3'd1;
    localparam logic [2:0] REG_MIN    = 3'd2;
    localparam logic [2:0] REG_MAX    = 3'd3;
    localparam logic [2:0] REG_START  = 3'd4;
    localparam logic [2:0] PH_FIRST  = 3'd0;
    localparam logic [2:0] PH_STATIC = 3'd1;
    localparam logic [2:0] PH_UP     = 3'd2;
    localparam logic [2:0] PH_DOWN   = 3'd3;
    localparam logic [2:0] PH_CURVE  = 3'd4;
    localparam logic [2:0] PH_PULSE  = 3'd5;
    localparam logic [31:0] RST_MIN   = 32'd1789570;
    localparam logic [31:0] RST_MAX   = 32'd89478485;
    localparam logic [31:0] RST_START = 32'd5965232;
    localparam logic [14:0] RST_TRANS = 15'd40;
endpackage
`default_nettype wire

[rtl/core/parameter_glide_smoother_top.sv]
// Parameter glide smoother top level: stream in, sample stream out.
// A tick passes through S_TICK, which loads the output register, and then S_OUT; a glide
// uses a shared 64x32 multiplier (two 32x32 products) and, in linear and cubic mode, a shared
// 128-step restoring divider. One item at a time: ready only in S_IDLE with no sample waiting.
// Reset: synchronous active-low i_rst_n clears state, registers take defaults.
// Depends on pgs_pkg.
`default_nettype none
module parameter_glide_smoother_top #(
    parameter int MAX_TRANSITION  = pgs_pkg::MAX_TRANSITION,
    parameter int INNER_FRAC_BITS = pgs_pkg::INNER_FRAC_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // value[31:0]
    input  wire logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // sample[31:0]
    output logic             m_axis_tuser,   // moving
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    import pgs_pkg::*;

    localparam int LSHIFT = INNER_FRAC_BITS - 24;
    localparam int NW = $clog2(MAX_TRANSITION + 1);
    localparam logic [63:0] TOP = 64'h8000000000000000;
    localparam logic [31:0] RECIP5 = 32'd3435973837;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_TICK  = 5'd1;
    localparam logic [4:0] S_OUT   = 5'd2;
    localparam logic [4:0] S_GL0   = 5'd3;
    localparam logic [4:0] S_MUL   = 5'd4;
    localparam logic [4:0] S_DIV   = 5'd5;
    localparam logic [4:0] S_LIN   = 5'd6;
    localparam logic [4:0] S_CN2   = 5'd7;
    localparam logic [4:0] S_CN3   = 5'd8;
    localparam logic [4:0] S_C1    = 5'd9;
    localparam logic [4:0] S_C2    = 5'd10;
    localparam logic [4:0] S_C3    = 5'd11;
    localparam logic [4:0] S_CFIN  = 5'd12;
    localparam logic [4:0] S_AD0   = 5'd13;
    localparam logic [4:0] S_AD1   = 5'd14;
    localparam logic [4:0] S_ADR   = 5'd15;

    localparam logic [1:0] MI_LIN   = 2'd0;
    localparam logic [1:0] MI_CURVE = 2'd1;
    localparam logic [1:0] MI_SHIFT = 2'd2;

    localparam logic [1:0] ADJ_KEEP   = 2'd0;
    localparam logic [1:0] ADJ_GROW   = 2'd1;
    localparam logic [1:0] ADJ_SHRINK = 2'd2;

    logic [1:0]  r_mode;
    logic [14:0] r_trans;
    logic [31:0] r_amin, r_amax, r_astart, r_arate;
    logic [63:0] r_cur, r_ssz, r_schg, r_cc;
    logic [31:0] r_goal, r_val;
    logic [NW-1:0] r_left;
    logic [2:0]  r_phase;
    logic [4:0]  r_st;
    logic        r_up;
    logic [63:0] r_mag, r_n3;
    logic [NW-1:0] r_n;
    // shared multiplier operands and 128/64 divider
    logic [63:0]  r_ma;
    logic [31:0]  r_mb;
    logic [1:0]   r_mi;
    logic [1:0]   r_adj;
    logic [127:0] r_prod;
    logic [127:0] r_num;
    logic [63:0]  r_den, r_rem, r_q;
    logic [6:0]   r_cnt;
    logic [1:0]   r_cstep;
    logic [31:0]  r_sample;
    logic         r_moving, r_ovalid;

    function automatic logic [63:0] widen(input logic [31:0] g);
        logic [95:0] x;
        x = {{64{g[31]}}, g} << LSHIFT;
        return x[63:0];
    endfunction

    function automatic logic sless(input logic [63:0] a, input logic [63:0] b);
        return (a ^ TOP) < (b ^ TOP);
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63]) r = a[63] ? TOP : ~TOP;
        return r;
    endfunction

    function automatic logic [31:0] to_sample(input logic [63:0] v);
        logic [64:0] t;
        logic signed [65:0] s;
        t = {1'b0, v ^ TOP} + (65'd1 << (LSHIFT - 1));
        s = $signed({1'b0, t >> LSHIFT}) - $signed(66'd1 << (63 - LSHIFT));
        if (s > 66'sd2147483647) return 32'h7FFFFFFF;
        if (s < -66'sd2147483648) return 32'h80000000;
        return s[31:0];
    endfunction

    logic [NW-1:0] w_neff;
    always_comb begin
        if (r_trans == 15'd0) w_neff = NW'(1);
        else if ({17'd0, r_trans} > 32'(MAX_TRANSITION)) w_neff = NW'(MAX_TRANSITION);
        else w_neff = NW'(r_trans);
    end

    logic [63:0] w_g;
    assign w_g = widen(r_goal);

    // divider step
    logic [64:0] w_rs;
    assign w_rs = {r_rem, r_num[127]};

    logic [63:0] w_mp;
    assign w_mp = r_ma[63:32] * r_mb;
    logic [63:0] w_ml;
    assign w_ml = r_ma[31:0] * r_mb;

    // adaptive rate: grow adds round(r/20), shrink drops round(r/10), /5 by reciprocal
    logic [33:0] w_ar10;
    assign w_ar10 = {2'd0, r_arate} + 34'd10;
    logic [32:0] w_ar4;
    assign w_ar4 = {1'b0, r_arate} + 33'd4;
    logic [32:0] w_grow;
    assign w_grow = {1'b0, r_arate} + {3'd0, w_ml[63:34]};

    logic [95:0] w_rnd;
    assign w_rnd = r_prod[95:0] + 96'h8000_0000;

    assign s_axis_tready = (r_st == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_sample;
    assign m_axis_tuser  = r_moving;

    logic [63:0] w_nm1;
    assign w_nm1 = 64'(r_n) - 64'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ovalid <= 1'b0; r_phase <= PH_FIRST;
            r_mode <= MODE_LINEAR; r_trans <= RST_TRANS; r_amin <= RST_MIN;
            r_amax <= RST_MAX; r_astart <= RST_START; r_arate <= RST_START;
            r_cur <= '0; r_goal <= '0; r_ssz <= '0; r_schg <= '0; r_cc <= '0;
            r_left <= '0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MODE:  begin r_mode <= i_cfg_data[1:0]; r_arate <= r_astart; end
                    REG_TRANS: r_trans <= i_cfg_data[14:0];
                    REG_MIN:   r_amin <= i_cfg_data;
                    REG_MAX:   r_amax <= i_cfg_data;
                    REG_START: r_astart <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_st)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_val <= s_axis_tdata; r_n <= w_neff;
                        case (s_axis_tuser)
                            KIND_TICK: r_st <= S_TICK;
                            KIND_GLIDE: r_st <= S_GL0;
                            KIND_SET: begin
                                r_phase <= PH_STATIC; r_goal <= s_axis_tdata;
                                r_cur <= widen(s_axis_tdata);
                            end
                            default: begin
                                r_goal <= s_axis_tdata; r_cur <= widen(s_axis_tdata);
                                r_phase <= PH_PULSE; r_left <= w_neff;
                            end
                        endcase
                    end
                end
                S_TICK: begin
                    r_moving <= 1'b1;
                    r_st <= S_OUT;
                    case (r_phase)
                        PH_PULSE: begin
                            if (r_left == '0) begin
                                r_goal <= '0; r_cur <= '0; r_phase <= PH_STATIC;
                                r_moving <= 1'b0; r_sample <= '0;
                            end else begin
                                r_left <= r_left - NW'(1); r_sample <= r_goal;
                            end
                        end
                        PH_UP: begin
                            if (!sless(r_cur, w_g) || r_ssz >= w_g - r_cur) begin
                                r_cur <= w_g; r_phase <= PH_STATIC; r_sample <= r_goal;
                            end else begin
                                r_cur <= r_cur + r_ssz; r_sample <= to_sample(r_cur + r_ssz);
                            end
                        end
                        PH_DOWN: begin
                            if (!sless(w_g, r_cur) || r_ssz >= r_cur - w_g) begin
                                r_cur <= w_g; r_phase <= PH_STATIC; r_sample <= r_goal;
                            end else begin
                                r_cur <= r_cur - r_ssz; r_sample <= to_sample(r_cur - r_ssz);
                            end
                        end
                        PH_CURVE: begin
                            if (r_left == '0) begin
                                r_cur <= w_g; r_phase <= PH_STATIC; r_sample <= r_goal;
                            end else begin
                                r_sample <= to_sample(r_cur);
                                r_left <= r_left - NW'(1);
                                r_cur <= sat_add(r_cur, r_ssz);
                                r_ssz <= r_ssz + r_schg;
                                r_schg <= r_schg + r_cc;
                            end
                        end
                        default: begin
                            r_phase <= PH_STATIC; r_moving <= 1'b0; r_sample <= r_goal;
                        end
                    endcase
                end
                S_OUT: begin
                    r_ovalid <= 1'b1; r_st <= S_IDLE;
                end
                S_GL0: begin
                    if (r_phase == PH_FIRST) begin
                        r_phase <= PH_STATIC; r_goal <= r_val; r_cur <= widen(r_val);
                        r_st <= S_IDLE;
                    end else begin
                        r_goal <= r_val;
                        if (widen(r_val) == r_cur) begin
                            r_phase <= PH_STATIC; r_st <= S_IDLE;
                        end else begin
                            r_up <= sless(r_cur, widen(r_val));
                            r_mag <= sless(r_cur, widen(r_val)) ? widen(r_val) - r_cur
                                                                : r_cur - widen(r_val);
                            if (r_mode == MODE_ADAPT) r_st <= S_AD0;
                            else if (r_mode == MODE_LINEAR) begin
                                r_ma <= 64'd1; r_mb <= 32'd1; r_st <= S_LIN;
                            end else if (r_n == NW'(1)) begin
                                r_phase <= PH_CURVE; r_cur <= widen(r_val);
                                r_ssz <= '0; r_schg <= '0; r_cc <= '0; r_left <= '0;
                                r_st <= S_IDLE;
                            end else begin
                                r_ma <= 64'(r_n); r_mb <= 32'(r_n); r_st <= S_CN2;
                            end
                        end
                    end
                end
                S_AD0: begin
                    if ((r_phase == PH_UP || r_phase == PH_DOWN) && r_arate < r_amax) begin
                        r_adj <= ADJ_GROW; r_ma <= {32'd0, w_ar10[33:2]};
                    end else if (!(r_phase == PH_UP || r_phase == PH_DOWN) &&
                                 r_arate > r_amin) begin
                        r_adj <= ADJ_SHRINK; r_ma <= {32'd0, w_ar4[32:1]};
                    end else begin
                        r_adj <= ADJ_KEEP; r_ma <= '0;
                    end
                    r_mb <= RECIP5;
                    r_st <= S_AD1;
                end
                S_AD1: begin
                    case (r_adj)
                        ADJ_GROW:   r_arate <= w_grow[32] ? 32'hFFFFFFFF : w_grow[31:0];
                        ADJ_SHRINK: r_arate <= r_arate - {2'd0, w_ml[63:34]};
                        default: ;
                    endcase
                    r_st <= S_ADR;
                end
                S_ADR: begin
                    r_ma <= r_mag; r_mb <= r_arate; r_mi <= MI_SHIFT; r_st <= S_MUL;
                end
                S_LIN: begin
                    r_ma <= r_mag; r_mb <= 32'd1; r_den <= 64'(r_n); r_mi <= MI_LIN;
                    r_st <= S_MUL;
                end
                S_CN2: begin
                    r_ma <= {32'd0, w_ml[31:0]}; r_mb <= 32'(r_n); r_st <= S_CN3;
                end
                S_CN3: begin
                    r_n3 <= w_ml; r_den <= w_ml; r_cstep <= 2'd0; r_st <= S_C1;
                end
                S_C1: begin
                    r_ma <= r_mag;
                    case (r_cstep)
                        2'd0: r_mb <= 32'(3 * 64'(r_n) - 64'd2);
                        2'd1: r_mb <= 32'(6 * (64'(r_n) - 64'd2));
                        default: r_mb <= 32'd12;
                    endcase
                    r_den <= r_n3; r_mi <= MI_CURVE; r_st <= S_MUL;
                end
                S_MUL: begin
                    r_prod <= {64'd0, w_ml} + ({64'd0, w_mp} << 32);
                    r_st <= S_C2;
                end
                S_C2: begin
                    if (r_mi == MI_SHIFT) begin
                        r_ssz <= w_rnd[95:32];
                        r_phase <= (r_up && w_rnd[95:32] != '0) ? PH_UP : PH_DOWN;
                        r_st <= S_IDLE;
                    end else begin
                        r_num <= r_prod + {65'd0, r_den[63:1]};
                        r_rem <= '0; r_q <= '0; r_cnt <= 7'd127; r_st <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_rs >= {1'b0, r_den}) begin
                        r_rem <= 64'(w_rs - {1'b0, r_den});
                        if (!r_cnt[6]) r_q[r_cnt[5:0]] <= 1'b1;
                    end else r_rem <= w_rs[63:0];
                    r_num <= r_num << 1;
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == 7'd0) r_st <= S_C3;
                end
                S_C3: begin
                    case (r_mi)
                        MI_LIN: begin
                            r_ssz <= r_q;
                            r_phase <= (r_up && r_q != '0) ? PH_UP : PH_DOWN;
                            r_st <= S_IDLE;
                        end
                        default: begin
                            case (r_cstep)
                                2'd0: r_ssz <= r_up ? r_q : -r_q;
                                2'd1: r_schg <= r_up ? r_q : -r_q;
                                default: r_cc <= r_up ? -r_q : r_q;
                            endcase
                            if (r_cstep == 2'd2) r_st <= S_CFIN;
                            else begin
                                r_cstep <= r_cstep + 2'd1; r_st <= S_C1;
                            end
                        end
                    endcase
                end
                S_CFIN: begin
                    r_phase <= PH_CURVE;
                    r_cur <= sat_add(r_cur, r_ssz);
                    r_ssz <= r_ssz + r_schg;
                    r_schg <= r_schg + r_cc;
                    r_left <= NW'(w_nm1);
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/core/pgs_checker.sv]
// Port-level checker for the parameter glide smoother, bound to the top level.
// Depends on parameter_glide_smoother_top_defines.svh and pgs_pkg.
`default_nettype none
`include "parameter_glide_smoother_top_defines.svh"
module pgs_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [1:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);
    import pgs_pkg::*;

    `PGS_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output dropped while stalled")
    `PGS_ASSERT(a_busy_after, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_TICK |=> !s_axis_tready, "ready during work")
    `PGS_ASSERT(a_no_ready_out, i_clk, i_rst_n, m_axis_tvalid |-> !s_axis_tready, "accepted with result pending")
    `PGS_ASSERT_RST(a_rst, i_clk, !i_rst_n |=> !m_axis_tvalid, "valid after reset")
endmodule
bind parameter_glide_smoother_top pgs_checker u_pgs_checker (.*);
`default_nettype wire

[verif/parameter_glide_smoother_top_test.sv]
// Self-checking test of parameter_glide_smoother_top: events and ticks go in over the stream
// port, each tick's sample and moving flag is checked against an in-bench predictor.
// Depends on pgs_pkg and the block's RTL.
`timescale 1ns / 100ps
module parameter_glide_smoother_top_test;
    import pgs_pkg::*;

    localparam int EVENT_SETTLE = 800;

    typedef struct packed {
        logic [31:0] sample;
        logic        moving;
    } t_glide_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    parameter_glide_smoother_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    t_glide_out  pending_samples[$];
    int          error_count = 0;
    int          burst_left  = 0;

    // predictor configuration and state
    logic [1:0]  cfg_mode;
    logic [14:0] cfg_len;
    logic [31:0] cfg_min, cfg_max, cfg_start;
    logic [63:0] lvl_q, step_q, accel_q, jerk_q;
    logic [31:0] goal_q, rate_q;
    logic [14:0] left_q;
    logic [2:0]  ph_q;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [63:0] widen(logic [31:0] g);
        return {g, 32'b0};
    endfunction

    function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
        logic [63:0] r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63])
            r = a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        return r;
    endfunction

    function automatic logic [31:0] level_to_sample(logic [63:0] v);
        logic [64:0]        q;
        logic signed [65:0] s;
        q = ({1'b0, v ^ 64'h8000_0000_0000_0000} + 65'h8000_0000) >> 32;
        s = $signed({1'b0, q}) - 66'sh8000_0000;
        if (s > 66'sh7FFF_FFFF)
            s = 66'sh7FFF_FFFF;
        if (s < -66'sh8000_0000)
            s = -66'sh8000_0000;
        return s[31:0];
    endfunction

    function automatic logic [63:0] scale_round(logic [63:0] a, logic [63:0] b, logic [63:0] d);
        logic [127:0] p;
        logic [127:0] q;
        p = {64'b0, a} * {64'b0, b};
        p = p + (d >> 1);
        q = p / {64'b0, d};
        return q[63:0];
    endfunction

    function automatic logic [63:0] ramp_len();
        if (cfg_len == 15'd0)
            return 64'd1;
        if (cfg_len > MAX_TRANSITION)
            return MAX_TRANSITION;
        return {49'b0, cfg_len};
    endfunction

    function automatic void apply_glide(logic [31:0] v);
        logic [63:0] g, mag, n, d, r, n3;
        logic        up;
        if (ph_q == PH_FIRST) begin
            ph_q = PH_STATIC; goal_q = v; lvl_q = widen(v);
            return;
        end
        goal_q = v;
        g = widen(v);
        if (g == lvl_q) begin
            ph_q = PH_STATIC;
            return;
        end
        up  = $signed(lvl_q) < $signed(g);
        mag = up ? g - lvl_q : lvl_q - g;
        n   = ramp_len();
        if (cfg_mode == MODE_LINEAR || cfg_mode == MODE_ADAPT) begin
            if (cfg_mode == MODE_ADAPT) begin
                if (ph_q == PH_UP || ph_q == PH_DOWN) begin
                    if (rate_q < cfg_max) begin
                        r = ({32'b0, rate_q} * 21 + 10) / 20;
                        rate_q = (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
                    end
                end else if (rate_q > cfg_min) begin
                    r = ({32'b0, rate_q} * 9 + 5) / 10;
                    rate_q = r[31:0];
                end
                d = scale_round(mag, {32'b0, rate_q}, 64'h1_0000_0000);
            end else begin
                d = scale_round(mag, 64'd1, n);
            end
            step_q = d;
            ph_q = (up && d != 0) ? PH_UP : PH_DOWN;
            return;
        end
        ph_q = PH_CURVE;
        if (n == 1) begin
            lvl_q = g; step_q = 0; accel_q = 0; jerk_q = 0; left_q = 0;
            return;
        end
        n3 = n * n * n;
        step_q  = scale_round(mag, 3 * n - 2, n3);
        accel_q = scale_round(mag, 6 * (n - 2), n3);
        jerk_q  = scale_round(mag, 64'd12, n3);
        if (!up) begin
            step_q = -step_q; accel_q = -accel_q;
        end else begin
            jerk_q = -jerk_q;
        end
        lvl_q   = sat_add(lvl_q, step_q);
        step_q  = step_q + accel_q;
        accel_q = accel_q + jerk_q;
        left_q  = 15'(n - 1);
    endfunction

    function automatic t_glide_out advance_tick();
        t_glide_out  o;
        logic [63:0] g;
        g = widen(goal_q);
        o.moving = 1'b1;
        case (ph_q)
            PH_PULSE: begin
                if (left_q == 0) begin
                    goal_q = 0; lvl_q = 0; ph_q = PH_STATIC;
                    o.moving = 1'b0; o.sample = 0;
                end else begin
                    left_q = left_q - 1;
                    o.sample = goal_q;
                end
            end
            PH_UP: begin
                if (!($signed(lvl_q) < $signed(g)) || step_q >= g - lvl_q) begin
                    lvl_q = g; ph_q = PH_STATIC; o.sample = goal_q;
                end else begin
                    lvl_q = lvl_q + step_q;
                    o.sample = level_to_sample(lvl_q);
                end
            end
            PH_DOWN: begin
                if (!($signed(g) < $signed(lvl_q)) || step_q >= lvl_q - g) begin
                    lvl_q = g; ph_q = PH_STATIC; o.sample = goal_q;
                end else begin
                    lvl_q = lvl_q - step_q;
                    o.sample = level_to_sample(lvl_q);
                end
            end
            PH_CURVE: begin
                o.sample = level_to_sample(lvl_q);
                if (left_q == 0) begin
                    lvl_q = g; ph_q = PH_STATIC; o.sample = goal_q;
                end else begin
                    left_q  = left_q - 1;
                    lvl_q   = sat_add(lvl_q, step_q);
                    step_q  = step_q + accel_q;
                    accel_q = accel_q + jerk_q;
                end
            end
            default: begin
                ph_q = PH_STATIC; o.moving = 1'b0; o.sample = goal_q;
            end
        endcase
        return o;
    endfunction

    function automatic void predict_item(logic [1:0] kind, logic [31:0] v);
        case (kind)
            KIND_TICK:  pending_samples.push_back(advance_tick());
            KIND_GLIDE: apply_glide(v);
            KIND_SET: begin
                ph_q = PH_STATIC; goal_q = v; lvl_q = widen(v);
            end
            default: begin
                goal_q = v; lvl_q = widen(v); ph_q = PH_PULSE;
                left_q = 15'(ramp_len());
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic send_item(logic [1:0] kind, logic [31:0] v);
        if (burst_left == 0) begin
            s_axis_tvalid = 1'b0;
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = kind;
        s_axis_tdata  = v;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_item(kind, v);
        @(negedge i_clk);
        burst_left--;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        s_axis_tvalid = 1'b0;
        burst_left = 0;
        while (pending_samples.size() != 0)
            @(negedge i_clk);
        repeat (EVENT_SETTLE) @(negedge i_clk);
        i_cfg_we = 1'b1; i_cfg_index = idx; i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_MODE: begin
                cfg_mode = data[1:0]; rate_q = cfg_start;
            end
            REG_TRANS: cfg_len   = data[14:0];
            REG_MIN:   cfg_min   = data;
            REG_MAX:   cfg_max   = data;
            REG_START: cfg_start = data;
            default: ;
        endcase
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            3: return goal_q + $urandom_range(0, 4096) - 2048;
            default: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
        endcase
    endfunction

    // output checker and receiver stall pattern
    initial begin
        t_glide_out want;
        int         stall_style;
        int         cyc;
        m_axis_tready = 1'b0;
        stall_style = 0;
        cyc = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                if (pending_samples.size() == 0) begin
                    report_mismatch("unexpected transfer", m_axis_tdata, 32'h0);
                end else begin
                    want = pending_samples.pop_front();
                    if (m_axis_tdata !== want.sample)
                        report_mismatch("sample", m_axis_tdata, want.sample);
                    if (m_axis_tuser !== want.moving)
                        report_mismatch("moving", {31'b0, m_axis_tuser}, {31'b0, want.moving});
                end
            end
            @(negedge i_clk);
            cyc++;
            if (cyc % 97 == 0)
                stall_style = $urandom_range(0, 3);
            case (stall_style)
                0: m_axis_tready = 1'b1;
                1: m_axis_tready = $urandom_range(0, 1);
                2: m_axis_tready = ($urandom_range(0, 3) == 0);
                default: m_axis_tready = ((cyc / 8) % 2 == 0);
            endcase
        end
    end

    task automatic test_first_glide_and_linear();
        write_reg(REG_TRANS, 32'd3);
        send_item(KIND_GLIDE, 32'h1234_5678);
        send_item(KIND_TICK, $urandom);
        send_item(KIND_SET, 32'h8000_0000);
        send_item(KIND_GLIDE, 32'h7FFF_FFFF);
        repeat (4) send_item(KIND_TICK, 32'h0);
        send_item(KIND_GLIDE, 32'h7FFF_FFFF);
        send_item(KIND_TICK, 32'hFFFF_FFFF);
    endtask

    task automatic test_pulse();
        send_item(KIND_PULSE, 32'h8000_0000);
        repeat (5) send_item(KIND_TICK, 32'h0);
    endtask

    task automatic test_curve_edges();
        write_reg(REG_MODE, 32'd2);
        write_reg(REG_TRANS, 32'd1);
        send_item(KIND_GLIDE, 32'h7FFF_FFFF);
        send_item(KIND_TICK, 32'h0);
        write_reg(REG_TRANS, 32'd0);
        send_item(KIND_GLIDE, 32'h8000_0000);
        send_item(KIND_TICK, 32'h0);
        write_reg(REG_TRANS, 32'd4);
        send_item(KIND_GLIDE, 32'h7FFF_FFFF);
        repeat (5) send_item(KIND_TICK, 32'h0);
    endtask

    task automatic test_adaptive_zero_rate();
        write_reg(REG_MIN, 32'd0);
        write_reg(REG_START, 32'd0);
        write_reg(REG_MAX, 32'hFFFF_FFFF);
        write_reg(REG_MODE, 32'd1);
        send_item(KIND_GLIDE, 32'h0100_0000);
        send_item(KIND_TICK, 32'h0);
        send_item(KIND_GLIDE, 32'hFF00_0000);
        repeat (2) send_item(KIND_TICK, 32'h0);
    endtask

    task automatic test_random_phases();
        logic [1:0] kind;
        int         pick;
        for (int phase_idx = 0; phase_idx < 6; phase_idx++) begin
            write_reg(REG_MODE, (phase_idx < 4) ? phase_idx : $urandom_range(0, 3));
            pick = $urandom_range(0, 9);
            write_reg(REG_TRANS, (pick == 0) ? 32'h7FFF : (pick == 1) ? MAX_TRANSITION :
                      (pick == 2) ? 32'd0 : $urandom_range(1, 12));
            write_reg(REG_MIN, $urandom_range(0, 3) == 0 ? 32'd0 : $urandom_range(0, 32'h0100_0000));
            write_reg(REG_MAX, $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom);
            write_reg(REG_START, $urandom);
            write_reg(REG_MODE, $urandom_range(0, 3));
            for (int k = 0; k < 70; k++) begin
                pick = $urandom_range(0, 99);
                kind = (pick < 68) ? KIND_TICK : (pick < 85) ? KIND_GLIDE :
                       (pick < 92) ? KIND_SET : KIND_PULSE;
                send_item(kind, pick_value());
            end
        end
    endtask

    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_TICK;
        i_cfg_we      = 1'b0;
        i_cfg_index   = REG_MODE;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;
        cfg_mode  = MODE_LINEAR; cfg_len = RST_TRANS;
        cfg_min   = RST_MIN;  cfg_max = RST_MAX; cfg_start = RST_START;
        lvl_q = 0; step_q = 0; accel_q = 0; jerk_q = 0;
        goal_q = 0; left_q = 0; ph_q = PH_FIRST; rate_q = RST_START;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_first_glide_and_linear();
        test_pulse();
        test_curve_edges();
        test_adaptive_zero_rate();
        test_random_phases();

        s_axis_tvalid = 1'b0;
        while (pending_samples.size() != 0)
            @(negedge i_clk);
        repeat (EVENT_SETTLE) @(negedge i_clk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

[parameter_glide_smoother_top.f]
+incdir+rtl/core
rtl/core/pgs_pkg.sv
rtl/core/parameter_glide_smoother_top.sv
rtl/core/pgs_checker.sv
verif/parameter_glide_smoother_top_test.sv
